// ===== hdl/sdpr_pkg.sv =====
// shared types and constants of the six axis step/dir packet receiver
// no dependencies
package sdpr_pkg;

    localparam int AXES_DEF       = 6;
    localparam int BUFFER_BYTES   = 32;
    localparam int LEN_MAX        = BUFFER_BYTES - 2;

    localparam logic [7:0]  SYNC_BYTE   = 8'hed;
    localparam logic [7:0]  RESYNC_CHAR = 8'h72;
    localparam logic [15:0] HASH_SEED   = 16'hbad1;
    localparam logic [15:0] HASH_MUL    = 16'h6967;
    localparam logic [15:0] HASH_ADD    = 16'h1551;
    localparam logic [15:0] DIST_CLAMP  = 16'd10000;

    localparam logic [15:0] RATE_NUM_RST  = 16'd25000;
    localparam logic [15:0] PHASE_CAP_RST = 16'd40000;
    localparam logic [15:0] TICK_CAP_RST  = 16'd10000;
    localparam logic [31:0] TIMEOUT_RST   = 32'd2000000;

    // configuration register indexes
    localparam logic [1:0] CFG_RATE_NUM  = 2'd0;
    localparam logic [1:0] CFG_PHASE_CAP = 2'd1;
    localparam logic [1:0] CFG_TICK_CAP  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // reply codes
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic [15:0] elapsed;
    } t_item;

endpackage

// ===== hdl/sdpr_front.sv =====
// input side: accepts items into a two entry queue
// depends on sdpr_pkg
module sdpr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sdpr_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output sdpr_pkg::t_item o_q_item
);

    sdpr_pkg::t_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_valid & o_ready;
    assign pop       = o_q_valid & i_q_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// ===== hdl/sdpr_back.sv =====
// execution side: framing, hash, decode, period division and tick stepping
// depends on sdpr_pkg
module sdpr_back #(
    parameter int AXES = sdpr_pkg::AXES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  sdpr_pkg::t_item i_q_item,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [AXES-1:0] o_step_pins,
    output logic [AXES-1:0] o_dir_pins,
    output logic            o_stepping,
    output logic [1:0]      o_reply,
    output logic [15:0]     o_io_bits,
    output logic            o_link_lost
);

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_DECODE = 4'd3;
    localparam logic [3:0] S_DLOAD  = 4'd4;
    localparam logic [3:0] S_DITER  = 4'd5;
    localparam logic [3:0] S_TICK   = 4'd6;
    localparam logic [3:0] S_TEND   = 4'd7;
    localparam logic [3:0] S_TCHK   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // configuration
    logic [15:0] r_rate_num, r_phase_cap, r_tick_cap;
    logic [31:0] r_timeout;

    // control state
    logic [3:0]  r_state;
    logic [5:0]  r_pos;
    logic [5:0]  r_len;
    logic        r_fin;
    logic [AX_W-1:0] r_ax;
    logic [4:0]  r_dcnt;
    logic [1:0]  r_reply;
    logic        r_change;
    logic        r_resync, r_lost;
    logic [31:0] r_silence;
    logic [AXES-1:0] r_step, r_dir;
    logic [15:0] r_io;
    logic [15:0] r_tgt [AXES];
    logic [15:0] r_apos [AXES];
    logic [15:0] r_per [AXES];
    logic [15:0] r_phase [AXES];

    // payload registers
    sdpr_pkg::t_item r_item;
    logic [7:0]  r_lo, r_b2;
    logic [15:0] r_hash, r_sum, r_chk, r_io_stg;
    logic [15:0] r_stg [AXES];
    logic [15:0] r_delta;
    logic [15:0] r_rem, r_quo, r_den;

    // output register
    logic            r_ovalid;
    logic [AXES-1:0] r_ostep, r_odir;
    logic            r_ostepping, r_olost;
    logic [1:0]      r_oreply;
    logic [15:0]     r_oio;

    assign o_q_ready   = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_step_pins = r_ostep;
    assign o_dir_pins  = r_odir;
    assign o_stepping  = r_ostepping;
    assign o_reply     = r_oreply;
    assign o_io_bits   = r_oio;
    assign o_link_lost = r_olost;

    // byte framing helpers
    logic [7:0]  ch;
    logic [15:0] word;
    logic [4:0]  widx;
    logic        last_byte;
    assign ch        = r_item.rx_byte;
    assign word      = {ch, r_lo};
    assign widx      = r_pos[5:1];
    assign last_byte = ({1'b0, r_pos} + 7'd1) >= ({1'b0, r_len} + 7'd2);

    // tick helpers for the current axis
    logic [15:0] t_tg, t_ps, t_ph, t_ph2, t_ph3, t_diff;
    logic        t_lv, t_fire, t_up;
    assign t_tg   = r_tgt[r_ax];
    assign t_ps   = r_apos[r_ax];
    assign t_lv   = r_step[r_ax];
    assign t_ph   = r_phase[r_ax] + r_delta;
    assign t_fire = t_lv || (t_ph >= r_per[r_ax]);
    assign t_ph2  = t_lv ? t_ph : t_ph - r_per[r_ax];
    assign t_ph3  = (t_ph2 > r_phase_cap) ? r_phase_cap : t_ph2;
    assign t_diff = t_tg - t_ps;
    assign t_up   = !t_diff[15] && (t_diff != 16'd0);

    // distance for the divider
    logic [15:0] d_abs, d_clamp;
    assign d_abs   = t_diff[15] ? (~t_diff + 16'd1) : t_diff;
    assign d_clamp = (t_diff == 16'h8000 || d_abs > sdpr_pkg::DIST_CLAMP) ?
                     sdpr_pkg::DIST_CLAMP :
                     ((d_abs < 16'd2) ? 16'd2 : d_abs);

    // restoring divider step
    logic [15:0] dv_sh;
    logic        dv_ge;
    assign dv_sh = {r_rem[14:0], r_quo[15]};
    assign dv_ge = dv_sh >= r_den;

    // hash multiply and silence add
    logic [31:0] h_prod;
    logic [32:0] sil_sum;
    assign h_prod  = r_sum * sdpr_pkg::HASH_MUL;
    assign sil_sum = {1'b0, r_silence} + {17'd0, r_delta};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_num  <= sdpr_pkg::RATE_NUM_RST;
            r_phase_cap <= sdpr_pkg::PHASE_CAP_RST;
            r_tick_cap  <= sdpr_pkg::TICK_CAP_RST;
            r_timeout   <= sdpr_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdpr_pkg::CFG_RATE_NUM:  r_rate_num  <= i_cfg_data[15:0];
                sdpr_pkg::CFG_PHASE_CAP: r_phase_cap <= i_cfg_data[15:0];
                sdpr_pkg::CFG_TICK_CAP:  r_tick_cap  <= i_cfg_data[15:0];
                sdpr_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload datapath without reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_item <= i_q_item;
        end
        if (r_state == S_EXEC && r_item.op == sdpr_pkg::OP_BYTE) begin
            if (r_pos == 6'd0) begin
                r_lo   <= ch;
                r_hash <= sdpr_pkg::HASH_SEED;
            end else if (!r_pos[0]) begin
                r_lo <= ch;
                if (r_pos == 6'd2) r_b2 <= ch;
            end else begin
                r_sum <= r_hash + word;
                if (r_pos != 6'd1) begin
                    if (widx >= 5'd1 && widx <= 5'(AXES)) begin
                        r_stg[AX_W'(widx - 5'd1)] <= word;
                    end
                    if (widx == 5'(AXES + 1)) r_io_stg <= word;
                    if (widx == 5'(AXES + 2)) r_chk <= word;
                end
            end
        end
        if (r_state == S_EXEC && r_item.op == sdpr_pkg::OP_TICK) begin
            r_delta <= (r_item.elapsed > r_tick_cap) ? r_tick_cap : r_item.elapsed;
        end
        if (r_state == S_HASH) begin
            r_hash <= h_prod[15:0] + sdpr_pkg::HASH_ADD;
        end
        if (r_state == S_DLOAD) begin
            r_rem <= 16'd0;
            r_quo <= r_rate_num;
            r_den <= d_clamp;
        end
        if (r_state == S_DITER) begin
            r_rem <= dv_ge ? (dv_sh - r_den) : dv_sh;
            r_quo <= {r_quo[14:0], dv_ge};
        end
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= 6'd0;
            r_len     <= 6'd0;
            r_fin     <= 1'b0;
            r_ax      <= '0;
            r_dcnt    <= 5'd0;
            r_reply   <= sdpr_pkg::REPLY_NONE;
            r_change  <= 1'b0;
            r_resync  <= 1'b1;
            r_lost    <= 1'b0;
            r_silence <= 32'd0;
            r_step    <= '0;
            r_dir     <= '0;
            r_io      <= 16'd0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_tgt[i]   <= 16'd0;
                r_apos[i]  <= 16'd0;
                r_per[i]   <= 16'd0;
                r_phase[i] <= 16'd0;
            end
        end else begin
            if (r_ovalid && i_ready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state  <= S_EXEC;
                        r_reply  <= sdpr_pkg::REPLY_NONE;
                        r_change <= 1'b0;
                        r_fin    <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (r_item.op == sdpr_pkg::OP_TICK) begin
                        r_ax    <= '0;
                        r_state <= S_TICK;
                    end else if (r_pos == 6'd0) begin
                        if (ch == sdpr_pkg::SYNC_BYTE) r_pos <= 6'd1;
                        r_state <= S_DONE;
                    end else if (r_pos == 6'd1) begin
                        if (ch > 8'(sdpr_pkg::LEN_MAX)) begin
                            r_pos   <= 6'd0;
                            r_len   <= 6'd0;
                            r_state <= S_DONE;
                        end else if (ch == 8'd0) begin
                            r_lost  <= 1'b1;
                            r_reply <= sdpr_pkg::REPLY_NAK;
                            r_pos   <= 6'd0;
                            r_len   <= 6'd0;
                            r_state <= S_DONE;
                        end else begin
                            r_len   <= ch[5:0];
                            r_pos   <= 6'd2;
                            r_state <= S_HASH;
                        end
                    end else begin
                        r_fin <= last_byte;
                        if (last_byte) begin
                            r_pos <= 6'd0;
                        end else begin
                            r_pos <= r_pos + 6'd1;
                        end
                        if (r_pos[0] && widx <= 5'(AXES + 1)) begin
                            r_state <= S_HASH;
                        end else begin
                            r_state <= last_byte ? S_DECODE : S_DONE;
                        end
                    end
                end
                S_HASH: begin
                    r_state <= r_fin ? S_DECODE : S_DONE;
                end
                S_DECODE: begin
                    r_len <= 6'd0;
                    if (r_len == 6'd1 && r_b2 == sdpr_pkg::RESYNC_CHAR) begin
                        r_resync <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (r_len != 6'(2 * AXES + 4) || r_chk != r_hash) begin
                        r_lost  <= 1'b1;
                        r_reply <= sdpr_pkg::REPLY_NAK;
                        r_state <= S_DONE;
                    end else begin
                        for (int i = 0; i < AXES; i++) begin
                            r_tgt[i] <= r_stg[i];
                            if (r_resync) r_apos[i] <= r_stg[i];
                        end
                        r_io      <= r_io_stg;
                        r_resync  <= 1'b0;
                        r_silence <= 32'd0;
                        r_lost    <= 1'b0;
                        r_reply   <= sdpr_pkg::REPLY_ACK;
                        r_ax      <= '0;
                        r_state   <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_dcnt  <= 5'd0;
                    r_state <= S_DITER;
                end
                S_DITER: begin
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd15) begin
                        r_per[r_ax] <= {r_quo[14:0], dv_ge};
                        if (r_ax == AX_W'(AXES - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_DLOAD;
                        end
                    end
                end
                S_TICK: begin
                    if (t_tg != t_ps) begin
                        r_phase[r_ax] <= t_fire ? t_ph3 : t_ph;
                        if (t_fire) begin
                            r_change     <= 1'b1;
                            r_step[r_ax] <= ~t_lv;
                            r_dir[r_ax]  <= t_up;
                            if (t_lv) r_apos[r_ax] <= t_up ? t_ps + 16'd1 : t_ps - 16'd1;
                        end
                    end
                    if (r_ax == AX_W'(AXES - 1)) begin
                        r_state <= S_TEND;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                S_TEND: begin
                    r_silence <= sil_sum[32] ? 32'hffff_ffff : sil_sum[31:0];
                    r_state   <= S_TCHK;
                end
                S_TCHK: begin
                    if (r_silence > r_timeout) begin
                        r_lost   <= 1'b1;
                        r_resync <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
            r_ostep     <= r_step;
            r_odir      <= r_dir;
            r_ostepping <= r_change;
            r_oreply    <= r_reply;
            r_oio       <= r_io;
            r_olost     <= r_lost;
        end
    end

endmodule

// ===== hdl/six_axis_step_dir_packet_receiver_top.sv =====
// six axis step/dir packet receiver, top level
// a byte passes through EXEC, an optional HASH step and DONE; a packet end adds DECODE and
// the period divider (16 steps each, per axis); a tick steps the axes one axis per cycle
// one item in the back end at a time, the next taken once DONE hands its result on;
// a two entry queue and the output register decouple the sides
// synchronous active low reset; configuration returns to its default values
// depends on sdpr_pkg, sdpr_front, sdpr_back
module six_axis_step_dir_packet_receiver_top #(
    parameter int AXES = sdpr_pkg::AXES_DEF,
    localparam int OUT_W  = 2 * AXES + 20,
    localparam int OUT_TD = ((OUT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,   // rx_byte[7:0], elapsed_time[23:8]
    input  logic              i_s_tuser,   // operation
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_TD-1:0] o_m_tdata,   // step_pins, dir_pins, stepping, reply, io_bits,
                                           // link_lost
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    sdpr_pkg::t_item in_item, q_item;
    logic            q_valid, q_ready;
    logic [AXES-1:0] step_pins, dir_pins;
    logic            stepping, link_lost;
    logic [1:0]      reply;
    logic [15:0]     io_bits;

    assign in_item.op      = i_s_tuser;
    assign in_item.rx_byte = i_s_tdata[7:0];
    assign in_item.elapsed = i_s_tdata[23:8];

    sdpr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    sdpr_back #(.AXES(AXES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_step_pins (step_pins),
        .o_dir_pins  (dir_pins),
        .o_stepping  (stepping),
        .o_reply     (reply),
        .o_io_bits   (io_bits),
        .o_link_lost (link_lost)
    );

    // pack result fields from the lowest bit up
    assign o_m_tdata = OUT_TD'({link_lost, io_bits, reply, stepping, dir_pins, step_pins});

endmodule

// ===== tb/six_axis_step_dir_packet_receiver_top_tb.sv =====
// testbench of the six axis step/dir packet receiver: byte and tick items in, one
// status item out per input, checked against a behavioral predictor
// depends on sdpr_pkg and six_axis_step_dir_packet_receiver_top
module six_axis_step_dir_packet_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAX = 6;
    localparam int OUT_TD = 32;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        link_lost;
        logic [15:0] io_bits;
        logic [1:0]  reply;
        logic        stepping;
        logic [5:0]  dir_pins;
        logic [5:0]  step_pins;
    } t_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [23:0]       i_s_tdata = '0;
    logic              i_s_tuser = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_TD-1:0] o_m_tdata;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [31:0]       i_cfg_data = '0;

    six_axis_step_dir_packet_receiver_top dut (.*);

    // predictor state
    logic [15:0] rate_num, phase_cap, tick_cap;
    logic [31:0] timeout_lim;
    logic [7:0]  frame [sdpr_pkg::BUFFER_BYTES];
    int          rx_pos, rx_end;
    logic [15:0] tgt [NAX], pos [NAX], per [NAX], ph [NAX];
    logic [5:0]  steps, dirs;
    logic [15:0] io_w;
    logic        resync, lost;
    logic [31:0] silence;

    t_status     status_q [$];
    int          errors = 0;
    int          send_idle = 0;   // percent
    int          recv_idle = 0;
    bit          hold_off = 0;
    longint      cycles = 0;

    initial forever #1 i_clk = ~i_clk;

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] frame16(int at);
        return {frame[at + 1], frame[at]};
    endfunction

    function automatic logic [15:0] frame_hash();
        logic [15:0] h;
        h = sdpr_pkg::HASH_SEED;
        for (int w = 0; w < NAX + 2; w++)
            h = (h + frame16(2 * w)) * sdpr_pkg::HASH_MUL + sdpr_pkg::HASH_ADD;
        return h;
    endfunction

    function automatic logic [15:0] hash_of(logic [7:0] b []);
        logic [15:0] h;
        h = sdpr_pkg::HASH_SEED;
        for (int w = 0; w < NAX + 2; w++)
            h = (h + {b[2 * w + 1], b[2 * w]}) * sdpr_pkg::HASH_MUL + sdpr_pkg::HASH_ADD;
        return h;
    endfunction

    task automatic predictor_reset();
        rate_num = sdpr_pkg::RATE_NUM_RST; phase_cap = sdpr_pkg::PHASE_CAP_RST;
        tick_cap = sdpr_pkg::TICK_CAP_RST; timeout_lim = sdpr_pkg::TIMEOUT_RST;
        rx_pos = 0; rx_end = 0;
        for (int i = 0; i < NAX; i++) begin
            tgt[i] = 0; pos[i] = 0; per[i] = 0; ph[i] = 0;
        end
        steps = 0; dirs = 0; io_w = 0; resync = 1; lost = 0; silence = 0;
    endtask

    function automatic logic [1:0] decode_frame();
        int d;
        if (frame[1] == 8'd1 && frame[2] == sdpr_pkg::RESYNC_CHAR) begin
            resync = 1;
            return sdpr_pkg::REPLY_NONE;
        end
        if (frame[1] != 2 * NAX + 4 || frame16(2 * NAX + 4) != frame_hash()) begin
            lost = 1;
            return sdpr_pkg::REPLY_NAK;
        end
        for (int i = 0; i < NAX; i++) tgt[i] = frame16(2 + 2 * i);
        io_w = frame16(2 * NAX + 2);
        if (resync) begin
            resync = 0;
            for (int i = 0; i < NAX; i++) pos[i] = tgt[i];
        end
        for (int i = 0; i < NAX; i++) begin
            d = $signed(tgt[i] - pos[i]);
            if (d < 0) d = -d;
            if (d > sdpr_pkg::DIST_CLAMP) d = sdpr_pkg::DIST_CLAMP;
            if (d < 2) d = 2;
            per[i] = rate_num / d;
        end
        silence = 0;
        lost = 0;
        return sdpr_pkg::REPLY_ACK;
    endfunction

    function automatic t_status predict_status(logic op, logic [7:0] ch, logic [15:0] dt);
        t_status s;
        logic [1:0] rep;
        logic chg;
        logic [31:0] delta;
        rep = sdpr_pkg::REPLY_NONE; chg = 0;
        if (op == sdpr_pkg::OP_BYTE) begin
            if (rx_pos == 0) begin
                if (ch == sdpr_pkg::SYNC_BYTE) begin frame[0] = ch; rx_pos = 1; end
            end else if (rx_pos == 1) begin
                if (ch > sdpr_pkg::LEN_MAX) begin
                    rx_pos = 0; rx_end = 0;
                end else if (ch == 0) begin
                    lost = 1; rep = sdpr_pkg::REPLY_NAK; rx_pos = 0; rx_end = 0;
                end else begin
                    frame[1] = ch; rx_end = 2 + ch; rx_pos = 2;
                end
            end else begin
                if (rx_pos < sdpr_pkg::BUFFER_BYTES) frame[rx_pos] = ch;
                rx_pos++;
                if (rx_pos >= rx_end || rx_pos >= sdpr_pkg::BUFFER_BYTES) begin
                    rep = decode_frame();
                    rx_pos = 0; rx_end = 0;
                end
            end
        end else begin
            delta = (dt > tick_cap) ? tick_cap : dt;
            for (int i = 0; i < NAX; i++) begin
                if (tgt[i] == pos[i]) continue;
                ph[i] = ph[i] + delta[15:0];
                if (steps[i] || ph[i] >= per[i]) begin
                    chg = 1;
                    if (!steps[i]) ph[i] = ph[i] - per[i];
                    if (ph[i] > phase_cap) ph[i] = phase_cap;
                    steps[i] = ~steps[i];
                    if ($signed(tgt[i] - pos[i]) > 0) begin
                        dirs[i] = 1;
                        if (!steps[i]) pos[i]++;
                    end else begin
                        dirs[i] = 0;
                        if (!steps[i]) pos[i]--;
                    end
                end
            end
            silence = (silence > 32'hffffffff - delta) ? 32'hffffffff : silence + delta;
            if (silence > timeout_lim) begin lost = 1; resync = 1; end
        end
        s.step_pins = steps; s.dir_pins = dirs; s.stepping = chg;
        s.reply = rep; s.io_bits = io_w; s.link_lost = lost;
        return s;
    endfunction

    // sender: one item, accepted when tvalid and tready meet; tvalid stays up
    // until the next idle gap or drain
    task automatic send_item(logic op, logic [7:0] ch, logic [15:0] dt);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {dt, ch};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        status_q.push_back(predict_status(op, ch, dt));
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(sdpr_pkg::OP_BYTE, b, 16'($urandom));
    endtask

    task automatic send_tick(logic [15:0] dt);
        send_item(sdpr_pkg::OP_TICK, 8'($urandom), dt);
    endtask

    // full packet of targets and io word, optionally corrupted check
    task automatic send_packet(logic [15:0] t [NAX], logic [15:0] io, bit corrupt);
        logic [7:0] b [] = new[2 * NAX + 6];
        logic [15:0] h;
        b[0] = sdpr_pkg::SYNC_BYTE; b[1] = 2 * NAX + 4;
        for (int i = 0; i < NAX; i++) begin
            b[2 + 2 * i] = t[i][7:0]; b[3 + 2 * i] = t[i][15:8];
        end
        b[2 * NAX + 2] = io[7:0]; b[2 * NAX + 3] = io[15:8];
        h = hash_of(b) ^ (corrupt ? 16'(1 << $urandom_range(15)) : 16'h0);
        b[2 * NAX + 4] = h[7:0]; b[2 * NAX + 5] = h[15:8];
        foreach (b[k]) send_byte(b[k]);
    endtask

    task automatic random_packet(bit corrupt);
        logic [15:0] t [NAX];
        for (int i = 0; i < NAX; i++)
            t[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(pos[i] + $urandom_range(60) - 30);
        send_packet(t, 16'($urandom), corrupt);
    endtask

    task automatic send_resync();
        send_byte(sdpr_pkg::SYNC_BYTE); send_byte(8'd1); send_byte(sdpr_pkg::RESYNC_CHAR);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        drain();
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sdpr_pkg::CFG_RATE_NUM:  rate_num = val[15:0];
            sdpr_pkg::CFG_PHASE_CAP: phase_cap = val[15:0];
            sdpr_pkg::CFG_TICK_CAP:  tick_cap = val[15:0];
            sdpr_pkg::CFG_TIMEOUT:   timeout_lim = val;
        endcase
    endtask

    // receiver readiness, long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) i_m_tready <= 1'b0;
        else i_m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // result checker
    always @(posedge i_clk) begin
        t_status got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_status'(o_m_tdata[2 * NAX + 19:0]);
            if (status_q.size() == 0) begin
                $error("result with no expected status");
                errors++;
            end else begin
                want = status_q.pop_front();
                if (got.step_pins !== want.step_pins) begin
                    $error("step_pins exp %h got %h", want.step_pins, got.step_pins); errors++;
                end
                if (got.dir_pins !== want.dir_pins) begin
                    $error("dir_pins exp %h got %h", want.dir_pins, got.dir_pins); errors++;
                end
                if (got.stepping !== want.stepping) begin
                    $error("stepping exp %h got %h", want.stepping, got.stepping); errors++;
                end
                if (got.reply !== want.reply) begin
                    $error("reply exp %h got %h", want.reply, got.reply); errors++;
                end
                if (got.io_bits !== want.io_bits) begin
                    $error("io_bits exp %h got %h", want.io_bits, got.io_bits); errors++;
                end
                if (got.link_lost !== want.link_lost) begin
                    $error("link_lost exp %h got %h", want.link_lost, got.link_lost); errors++;
                end
            end
        end
    end

    // directed: framing corner cases
    task automatic test_framing();
        logic [15:0] t [NAX];
        send_byte(8'h00); send_byte(8'hff);                           // noise while idle
        send_byte(sdpr_pkg::SYNC_BYTE); send_byte(8'd0);              // empty packet
        send_byte(sdpr_pkg::SYNC_BYTE); send_byte(8'd31);             // oversized, dropped
        send_byte(sdpr_pkg::SYNC_BYTE); send_byte(8'hff);
        send_resync();
        send_byte(sdpr_pkg::SYNC_BYTE); send_byte(8'd2); send_byte(8'h55); send_byte(8'haa);
        for (int i = 0; i < NAX; i++) t[i] = (i % 2) ? 16'hffff : 16'h0000;
        send_packet(t, 16'hffff, 0);
        for (int i = 0; i < NAX; i++) t[i] = (i % 2) ? 16'h7fff : 16'h8000;
        send_packet(t, 16'h0000, 0);
        send_packet(t, 16'h1234, 1);
    endtask

    // directed: ticks at extremes
    task automatic test_ticks();
        send_tick(16'h0000); send_tick(16'hffff);
        for (int k = 0; k < 6; k++) send_tick(16'($urandom_range(2000)));
    endtask

    // random mix: well-formed packets with ticks, some noise and broken frames
    task automatic test_random(int n_items);
        int sent;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 45) begin random_packet(0); sent += 2 * NAX + 6; end
            else if (r < 50) begin random_packet(1); sent += 2 * NAX + 6; end
            else if (r < 53) begin send_resync(); sent += 3; end
            else if (r < 56) begin
                send_byte(sdpr_pkg::SYNC_BYTE); send_byte(8'($urandom_range(sdpr_pkg::LEN_MAX)));
                repeat ($urandom_range(8)) send_byte(8'($urandom));
                sent += 4;
            end else begin
                send_tick(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600)));
                sent++;
            end
        end
    endtask

    // pressure: receiver holds off while items keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 40; k++) send_tick(16'($urandom_range(300)));
        join
        drain();
    endtask

    task automatic test_config();
        write_cfg(sdpr_pkg::CFG_RATE_NUM, 32'd1);
        write_cfg(sdpr_pkg::CFG_PHASE_CAP, 32'd0);
        write_cfg(sdpr_pkg::CFG_TICK_CAP, 32'd65535);
        write_cfg(sdpr_pkg::CFG_TIMEOUT, 32'd0);
        test_random(150);
        write_cfg(sdpr_pkg::CFG_RATE_NUM, 32'd65535);
        write_cfg(sdpr_pkg::CFG_PHASE_CAP, 32'd65535);
        write_cfg(sdpr_pkg::CFG_TICK_CAP, 32'd0);
        write_cfg(sdpr_pkg::CFG_TIMEOUT, 32'hffffffff);
        test_random(150);
        write_cfg(sdpr_pkg::CFG_RATE_NUM, 32'd3000);
        write_cfg(sdpr_pkg::CFG_PHASE_CAP, 32'd500);
        write_cfg(sdpr_pkg::CFG_TICK_CAP, 32'd400);
        write_cfg(sdpr_pkg::CFG_TIMEOUT, 32'd5000);
    endtask

    initial begin
        predictor_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_framing();
        test_ticks();
        send_idle = 0; recv_idle = 0;  test_random(300);
        send_idle = 60; recv_idle = 0; test_random(250);
        send_idle = 0; recv_idle = 60; test_random(250);
        send_idle = 19; recv_idle = 19; test_random(250);
        drain();                       // sender pauses until all results are in
        test_backpressure();
        test_config();
        send_idle = 19; recv_idle = 19; test_random(300);
        drain();
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
